[rtl/core/psb_pkg.sv]
// ----------------------------------------------------------------------------
// psb_pkg
// Shared widths, register indexes and stage payload types for the
// point-to-sphere blend pipeline.
// ----------------------------------------------------------------------------
package psb_pkg;

  localparam int CRD_W  = 32;          // Q16.16 coordinate
  localparam int D_W    = 33;          // offset / magnitude
  localparam int SQ_W   = 66;          // squared length, Q34.32
  localparam int RB     = 34;          // root bits produced by the sqrt
  localparam int R_W    = 33;          // root width actually reachable
  localparam int T_W    = 17;          // Q1.16 blend factor
  localparam int TR_W   = 31;          // target radius
  localparam int NUM_W  = 67;          // division numerator
  localparam int QB     = 40;          // quotient bits below the cap
  localparam int IDX_W  = 2;
  localparam int DAT_W  = 32;

  localparam logic [T_W-1:0]   ONE_Q16 = 17'd65536;
  localparam logic [IDX_W-1:0] CFG_BLEND_RATIO    = 2'd0;
  localparam logic [IDX_W-1:0] CFG_TARGET_RADIUS  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_USE_OWN_CENTER = 2'd2;

  typedef logic [CRD_W-1:0] crd_t;
  typedef logic [D_W-1:0]   mag_t;

  // item data carried alongside the square root
  typedef struct packed {
    crd_t [2:0]  ctr;
    logic [2:0]  neg;
    mag_t [2:0]  mag;
    logic [T_W-1:0] t;
  } side_t;

  // item data carried alongside the divider
  typedef struct packed {
    crd_t [2:0] ctr;
    logic [2:0] neg;
    logic       zero;
  } tail_t;

endpackage

[rtl/core/psb_sqrt.sv]
// ----------------------------------------------------------------------------
// psb_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module psb_sqrt import psb_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [SQ_W-1:0] in_sum,
  input  side_t           in_side,
  output logic            out_vld,
  output logic [R_W-1:0]  out_root,
  output side_t           out_side
);

  logic            vld  [1:RB];
  logic [SQ_W-1:0] rem  [1:RB];
  logic [RB-1:0]   root [1:RB];
  side_t           side [1:RB];

  for (genvar i = 0; i < RB; i++) begin : g_st
    localparam int B = RB - 1 - i;
    logic            c_vld;
    logic [SQ_W-1:0] c_rem;
    logic [RB-1:0]   c_root;
    side_t           c_side;
    logic [SQ_W+1:0] trial;
    logic            take;

    if (i == 0) begin : g_first
      assign c_vld  = in_vld;
      assign c_rem  = in_sum;
      assign c_root = '0;
      assign c_side = in_side;
    end else begin : g_next
      assign c_vld  = vld[i];
      assign c_rem  = rem[i];
      assign c_root = root[i];
      assign c_side = side[i];
    end

    // (root + 2^B)^2 - root^2
    assign trial = ({{(SQ_W+2-RB){1'b0}}, c_root} << (B + 1))
                 + ((SQ_W+2)'(1) << (2 * B));
    assign take  = {2'b00, c_rem} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= take ? c_rem - trial[SQ_W-1:0] : c_rem;
        root[i+1] <= take ? (c_root | (RB'(1) << B)) : c_root;
        side[i+1] <= c_side;
      end
    end
  end

  assign out_vld  = vld[RB];
  assign out_root = root[RB][R_W-1:0];
  assign out_side = side[RB];

endmodule

[rtl/core/psb_div.sv]
// ----------------------------------------------------------------------------
// psb_div
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module psb_div import psb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [R_W-1:0]        in_den,
  input  logic [2:0][R_W:0]     in_rem,
  input  logic [2:0][QB-1:0]    in_lo,
  input  logic [2:0]            in_ovf,
  input  tail_t                 in_tail,
  output logic                  out_vld,
  output logic [2:0][QB-1:0]    out_q,
  output logic [2:0]            out_ovf,
  output tail_t                 out_tail
);

  logic                 vld  [1:QB];
  logic [R_W-1:0]       den  [1:QB];
  logic [2:0][R_W:0]    rem  [1:QB];
  logic [2:0][QB-1:0]   lo   [1:QB];
  logic [2:0][QB-1:0]   q    [1:QB];
  logic [2:0]           ovf  [1:QB];
  tail_t                tail [1:QB];

  for (genvar i = 0; i < QB; i++) begin : g_st
    logic               c_vld;
    logic [R_W-1:0]     c_den;
    logic [2:0][R_W:0]  c_rem;
    logic [2:0][QB-1:0] c_lo;
    logic [2:0][QB-1:0] c_q;
    logic [2:0]         c_ovf;
    tail_t              c_tail;
    logic [2:0][R_W:0]  n_rem;
    logic [2:0]         qb;

    if (i == 0) begin : g_first
      assign c_vld  = in_vld;
      assign c_den  = in_den;
      assign c_rem  = in_rem;
      assign c_lo   = in_lo;
      assign c_q    = '0;
      assign c_ovf  = in_ovf;
      assign c_tail = in_tail;
    end else begin : g_next
      assign c_vld  = vld[i];
      assign c_den  = den[i];
      assign c_rem  = rem[i];
      assign c_lo   = lo[i];
      assign c_q    = q[i];
      assign c_ovf  = ovf[i];
      assign c_tail = tail[i];
    end

    always_comb begin
      logic [R_W+1:0] shifted;
      logic [R_W+1:0] dext;
      dext = {2'b00, c_den};
      for (int k = 0; k < 3; k++) begin
        shifted  = {c_rem[k], c_lo[k][QB-1]};
        qb[k]    = shifted >= dext;
        n_rem[k] = qb[k] ? (R_W+1)'(shifted - dext) : (R_W+1)'(shifted);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den[i+1]  <= c_den;
        rem[i+1]  <= n_rem;
        ovf[i+1]  <= c_ovf;
        tail[i+1] <= c_tail;
        for (int k = 0; k < 3; k++) begin
          lo[i+1][k] <= {c_lo[k][QB-2:0], 1'b0};
          q[i+1][k]  <= {c_q[k][QB-2:0], qb[k]};
        end
      end
    end
  end

  assign out_vld  = vld[QB];
  assign out_q    = q[QB];
  assign out_ovf  = ovf[QB];
  assign out_tail = tail[QB];

endmodule

[rtl/core/point_to_sphere_blend.sv]
// ----------------------------------------------------------------------------
// point_to_sphere_blend
// Pulls a 3-D point toward a sphere of configured radius around a center.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one point, both centers and a
//   weight; output channel out_valid/out_stall returns the new point.
//   Config writes go over cfg_valid/cfg_ready (always ready) with cfg_index
//   0 = blend_ratio, 1 = target_radius, 2 = use_own_center; other indexes
//   are ignored. Write config only while the pipe is empty.
//   Throughput: one item per cycle while out_stall does not hold the pipe.
//   Stages to out_valid: 3 front stages, 34 sqrt stages (one root bit each),
//   2 stages for the new length, 3 for product/rounding/overflow check, 40
//   divider stages (one quotient bit each) and the output register.
//   Reset (rst, synchronous) empties the pipe and zeroes the config.
//   When out_stall is high with a result waiting, the whole pipe holds and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module point_to_sphere_blend import psb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [DAT_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [CRD_W-1:0] pos_x,
  input  logic signed [CRD_W-1:0] pos_y,
  input  logic signed [CRD_W-1:0] pos_z,
  input  logic signed [CRD_W-1:0] own_ctr_x,
  input  logic signed [CRD_W-1:0] own_ctr_y,
  input  logic signed [CRD_W-1:0] own_ctr_z,
  input  logic signed [CRD_W-1:0] grp_ctr_x,
  input  logic signed [CRD_W-1:0] grp_ctr_y,
  input  logic signed [CRD_W-1:0] grp_ctr_z,
  input  logic [T_W-1:0]         weight,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [CRD_W-1:0] out_x,
  output logic signed [CRD_W-1:0] out_y,
  output logic signed [CRD_W-1:0] out_z
);

  // config registers
  logic [T_W-1:0]  blend_ratio;
  logic [TR_W-1:0] target_radius;
  logic            use_own_center;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_ratio    <= '0;
      target_radius  <= '0;
      use_own_center <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BLEND_RATIO:    blend_ratio    <= cfg_data[T_W-1:0];
        CFG_TARGET_RADIUS:  target_radius  <= cfg_data[TR_W-1:0];
        CFG_USE_OWN_CENTER: use_own_center <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // global hold: everything advances unless a result is stuck at the output
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // ---- stage 1: center select, offset, magnitude, blend factor
  crd_t [2:0] pos_a, own_a, grp_a;
  side_t      s1_next;
  assign pos_a = {pos_z, pos_y, pos_x};
  assign own_a = {own_ctr_z, own_ctr_y, own_ctr_x};
  assign grp_a = {grp_ctr_z, grp_ctr_y, grp_ctr_x};

  always_comb begin
    logic [D_W-1:0] d;
    logic [T_W-1:0] rc, wc;
    logic [D_W:0]   tp;
    for (int k = 0; k < 3; k++) begin
      s1_next.ctr[k] = use_own_center ? own_a[k] : grp_a[k];
      d = {pos_a[k][CRD_W-1], pos_a[k]} - {s1_next.ctr[k][CRD_W-1], s1_next.ctr[k]};
      s1_next.neg[k] = d[D_W-1];
      s1_next.mag[k] = d[D_W-1] ? -d : d;
    end
    // clamp to 1.0, then t = round(ratio * weight)
    rc = (blend_ratio > ONE_Q16) ? ONE_Q16 : blend_ratio;
    wc = (weight > ONE_Q16) ? ONE_Q16 : weight;
    tp = (D_W+1)'(rc) * (D_W+1)'(wc) + (D_W+1)'(32768);
    s1_next.t = tp[16 +: T_W];
  end

  logic  s1_vld;
  side_t s1_side;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_side <= s1_next;
    end
  end

  // ---- stage 2: squares
  logic                 s2_vld;
  logic [2:0][SQ_W-1:0] s2_sq;
  side_t                s2_side;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s2_sq[k] <= SQ_W'(s1_side.mag[k]) * SQ_W'(s1_side.mag[k]);
      end
      s2_side <= s1_side;
    end
  end

  // ---- stage 3: sum of squares (fits 66 bits)
  logic            s3_vld;
  logic [SQ_W-1:0] s3_sum;
  side_t           s3_side;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_sum  <= s2_sq[0] + s2_sq[1] + s2_sq[2];
      s3_side <= s2_side;
    end
  end

  // ---- square root
  logic           sq_vld;
  logic [R_W-1:0] sq_root;
  side_t          sq_side;

  psb_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s3_vld),
    .in_sum   (s3_sum),
    .in_side  (s3_side),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // ---- L1: |target - r| * t
  logic [R_W-1:0] tr_ext;
  logic           l1_dneg_next;
  logic [R_W-1:0] l1_absd;
  assign tr_ext       = R_W'(target_radius);
  assign l1_dneg_next = sq_root > tr_ext;
  assign l1_absd      = l1_dneg_next ? sq_root - tr_ext : tr_ext - sq_root;

  logic                 l1_vld;
  logic                 l1_dneg;
  logic [R_W-1:0]       l1_r;
  logic [R_W+T_W-1:0]   l1_pd;
  side_t                l1_side;
  always_ff @(posedge clk) begin
    if (rst) begin
      l1_vld <= 1'b0;
    end else if (en) begin
      l1_vld <= sq_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      l1_dneg <= l1_dneg_next;
      l1_r    <= sq_root;
      l1_pd   <= (R_W+T_W)'(l1_absd) * (R_W+T_W)'(sq_side.t);
      l1_side <= sq_side;
    end
  end

  // ---- L2: rounded step, new length
  logic [R_W+T_W:0]   l2_rnd;
  logic [R_W+2:0]     l2_adj;
  logic [R_W+2:0]     l2_len_w;
  assign l2_rnd   = {1'b0, l1_pd} + (R_W+T_W+1)'(32768);
  assign l2_adj   = (R_W+3)'(l2_rnd[R_W+T_W:16]);
  assign l2_len_w = l1_dneg ? (R_W+3)'(l1_r) - l2_adj : (R_W+3)'(l1_r) + l2_adj;

  logic           l2_vld;
  logic [R_W-1:0] l2_len;
  logic [R_W-1:0] l2_r;
  side_t          l2_side;
  always_ff @(posedge clk) begin
    if (rst) begin
      l2_vld <= 1'b0;
    end else if (en) begin
      l2_vld <= l1_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      l2_len  <= l2_len_w[R_W-1:0];
      l2_r    <= l1_r;
      l2_side <= l1_side;
    end
  end

  // ---- M1: |d| * L
  logic                 m1_vld;
  logic [2:0][SQ_W-1:0] m1_prod;
  logic [R_W-1:0]       m1_r;
  tail_t                m1_tail;
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else if (en) begin
      m1_vld <= l2_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m1_prod[k] <= SQ_W'(l2_side.mag[k]) * SQ_W'(l2_len);
      end
      m1_r         <= l2_r;
      m1_tail.ctr  <= l2_side.ctr;
      m1_tail.neg  <= l2_side.neg;
      m1_tail.zero <= (l2_r == '0);
    end
  end

  // ---- M2: add half divisor for rounding
  logic                  m2_vld;
  logic [2:0][NUM_W-1:0] m2_num;
  logic [R_W-1:0]        m2_r;
  tail_t                 m2_tail;
  always_ff @(posedge clk) begin
    if (rst) begin
      m2_vld <= 1'b0;
    end else if (en) begin
      m2_vld <= m1_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m2_num[k] <= {1'b0, m1_prod[k]} + NUM_W'(m1_r >> 1);
      end
      m2_r    <= m1_r;
      m2_tail <= m1_tail;
    end
  end

  // ---- M3: quotient cap check; the high part seeds the remainder
  logic                  m3_vld;
  logic [2:0][R_W:0]     m3_rem;
  logic [2:0][QB-1:0]    m3_lo;
  logic [2:0]            m3_ovf;
  logic [R_W-1:0]        m3_r;
  tail_t                 m3_tail;
  always_ff @(posedge clk) begin
    if (rst) begin
      m3_vld <= 1'b0;
    end else if (en) begin
      m3_vld <= m2_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m3_ovf[k] <= R_W'(m2_num[k][NUM_W-1:QB]) >= m2_r;
        m3_rem[k] <= (R_W+1)'(m2_num[k][NUM_W-1:QB]);
        m3_lo[k]  <= m2_num[k][QB-1:0];
      end
      m3_r    <= m2_r;
      m3_tail <= m2_tail;
    end
  end

  // ---- divider
  logic               dv_vld;
  logic [2:0][QB-1:0] dv_q;
  logic [2:0]         dv_ovf;
  tail_t              dv_tail;

  psb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (m3_vld),
    .in_den   (m3_r),
    .in_rem   (m3_rem),
    .in_lo    (m3_lo),
    .in_ovf   (m3_ovf),
    .in_tail  (m3_tail),
    .out_vld  (dv_vld),
    .out_q    (dv_q),
    .out_ovf  (dv_ovf),
    .out_tail (dv_tail)
  );

  // ---- output: signed add to center, saturate; center alone when the length is zero
  crd_t [2:0] res;
  always_comb begin
    logic [QB:0]         qf;
    logic signed [QB+1:0] sq;
    logic signed [QB+2:0] sum;
    for (int k = 0; k < 3; k++) begin
      qf  = dv_ovf[k] ? ((QB+1)'(1) << QB) : {1'b0, dv_q[k]};
      sq  = dv_tail.neg[k] ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
      sum = $signed({{(QB+3-CRD_W){dv_tail.ctr[k][CRD_W-1]}}, dv_tail.ctr[k]})
          + $signed({sq[QB+1], sq});
      if (dv_tail.zero) begin
        res[k] = dv_tail.ctr[k];
      end else if (!sum[QB+2] && (sum[QB+1:CRD_W-1] != '0)) begin
        res[k] = {1'b0, {(CRD_W-1){1'b1}}};
      end else if (sum[QB+2] && (sum[QB+1:CRD_W-1] != '1)) begin
        res[k] = {1'b1, {(CRD_W-1){1'b0}}};
      end else begin
        res[k] = sum[CRD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_x <= res[0];
      out_y <= res[1];
      out_z <= res[2];
    end
  end

endmodule

[bench/psb_checker.sv]
// ----------------------------------------------------------------------------
// psb_checker
// Watches the point, result and config channels of point_to_sphere_blend,
// predicts each new point and compares it field by field, in order.
// ----------------------------------------------------------------------------
module psb_checker import psb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [DAT_W-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [CRD_W-1:0] pos_x,
  input  logic signed [CRD_W-1:0] pos_y,
  input  logic signed [CRD_W-1:0] pos_z,
  input  logic signed [CRD_W-1:0] own_ctr_x,
  input  logic signed [CRD_W-1:0] own_ctr_y,
  input  logic signed [CRD_W-1:0] own_ctr_z,
  input  logic signed [CRD_W-1:0] grp_ctr_x,
  input  logic signed [CRD_W-1:0] grp_ctr_y,
  input  logic signed [CRD_W-1:0] grp_ctr_z,
  input  logic [T_W-1:0]          weight,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [CRD_W-1:0] out_x,
  input  logic signed [CRD_W-1:0] out_y,
  input  logic signed [CRD_W-1:0] out_z,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    crd_t x;
    crd_t y;
    crd_t z;
  } point_t;

  logic [T_W-1:0]  ratio_reg;
  logic [TR_W-1:0] radius_reg;
  logic            own_sel_reg;
  point_t          points_due[$];

  function automatic logic [32:0] isqrt(logic [67:0] s);
    logic [33:0] root;
    logic [33:0] cand;
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (34'd1 << b);
      if ({34'd0, cand} * {34'd0, cand} <= s)
        root = cand;
    end
    return root[32:0];
  endfunction

  function automatic crd_t clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647)
      return 32'h7fffffff;
    if (v < -64'sd2147483648)
      return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic point_t blend_point(crd_t p[3], crd_t c[3], logic [T_W-1:0] w);
    logic signed [63:0] ctr[3];
    logic signed [63:0] d[3];
    logic [63:0]  mag[3];
    logic [67:0]  sum;
    logic [63:0]  r;
    logic [63:0]  rat;
    logic [63:0]  wt;
    logic [63:0]  t;
    logic [63:0]  len;
    logic [63:0]  gap;
    logic [127:0] num;
    logic [127:0] q;
    crd_t         res[3];
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      ctr[k] = {{32{c[k][31]}}, c[k]};
      d[k]   = {{32{p[k][31]}}, p[k]} - ctr[k];
      mag[k] = d[k] < 0 ? -d[k] : d[k];
      sum += 68'(mag[k]) * 68'(mag[k]);
    end
    r = 64'(isqrt(sum));
    if (r == 0)
      return '{x: c[0], y: c[1], z: c[2]};
    rat = ratio_reg > ONE_Q16 ? 64'(ONE_Q16) : 64'(ratio_reg);
    wt  = w > ONE_Q16 ? 64'(ONE_Q16) : 64'(w);
    t   = (rat * wt + 64'd32768) >> 16;
    if (64'(radius_reg) >= r) begin
      gap = 64'(radius_reg) - r;
      len = r + ((gap * t + 64'd32768) >> 16);
    end else begin
      gap = r - 64'(radius_reg);
      len = r - ((gap * t + 64'd32768) >> 16);
    end
    for (int k = 0; k < 3; k++) begin
      num = 128'(mag[k]) * 128'(len) + 128'(r >> 1);
      q   = num / 128'(r);
      if (q > (128'd1 << 40))
        q = 128'd1 << 40;
      res[k] = clamp32(d[k] < 0 ? ctr[k] - $signed(q[63:0])
                                : ctr[k] + $signed(q[63:0]));
    end
    return '{x: res[0], y: res[1], z: res[2]};
  endfunction

  task automatic compare_field(string name, crd_t want, crd_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  assign pending = points_due.size();

  always @(posedge clk) begin
    crd_t   p[3];
    crd_t   c[3];
    point_t want;
    if (rst) begin
      ratio_reg   <= '0;
      radius_reg  <= '0;
      own_sel_reg <= 1'b0;
      fail_count  = 0;
    end else begin
      if (in_valid && !in_stall) begin
        p = '{pos_x, pos_y, pos_z};
        if (own_sel_reg)
          c = '{own_ctr_x, own_ctr_y, own_ctr_z};
        else
          c = '{grp_ctr_x, grp_ctr_y, grp_ctr_z};
        points_due.push_back(blend_point(p, c, weight));
      end
      if (out_valid && !out_stall) begin
        if (points_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h %h %h",
                   $time, out_x, out_y, out_z);
          fail_count++;
        end else begin
          want = points_due.pop_front();
          compare_field("out_x", want.x, out_x);
          compare_field("out_y", want.y, out_y);
          compare_field("out_z", want.z, out_z);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLEND_RATIO:    ratio_reg <= cfg_data[T_W-1:0];
          CFG_TARGET_RADIUS:  radius_reg <= cfg_data[TR_W-1:0];
          CFG_USE_OWN_CENTER: own_sel_reg <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives point_to_sphere_blend through several register settings with
// directed and random points under random idling on both channels; the
// checker predicts and compares every new point.
// ----------------------------------------------------------------------------
module testbench import psb_pkg::*;;

  localparam int LATENCY   = 83;
  localparam int WDOG_MAX  = 4000;
  localparam int N_PHASES  = 6;
  localparam int PER_PHASE = 200;

  logic                    clk;
  logic                    rst;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index;
  logic [DAT_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [CRD_W-1:0] pos_x, pos_y, pos_z;
  logic signed [CRD_W-1:0] own_ctr_x, own_ctr_y, own_ctr_z;
  logic signed [CRD_W-1:0] grp_ctr_x, grp_ctr_y, grp_ctr_z;
  logic [T_W-1:0]          weight;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [CRD_W-1:0] out_x, out_y, out_z;
  int                      fail_count;
  int                      pending;

  // sink behavior: 0 random bursts, 1 long hold-off, 2 never stall
  int  sink_mode;
  int  idle_cycles;
  bit  sender_quiet;   // last part of the run: no input gaps

  point_to_sphere_blend i_dut (.*);

  psb_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: cycles in which nothing moves on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // output stall: random bursts, one long hold-off, or none
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_mode == 1) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        out_stall <= 1'b0;
        sink_mode = 0;
      end else if (sink_mode == 0 && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 3) == 0 ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 8000000)) - 4000000);
    endcase
  endfunction

  function automatic logic [T_W-1:0] rand_weight();
    case ($urandom_range(0, 3))
      0: return ONE_Q16;
      1: return T_W'($urandom_range(65537, 131071));
      default: return T_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // offers one point and holds it until accepted; gap decided beforehand
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                            logic [T_W-1:0] w);
    if (!sender_quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    pos_x     <= px;
    pos_y     <= py;
    pos_z     <= pz;
    own_ctr_x <= ox;
    own_ctr_y <= oy;
    own_ctr_z <= oz;
    grp_ctr_x <= gx;
    grp_ctr_y <= gy;
    grp_ctr_z <= gz;
    weight    <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [31:0] c[6];
    for (int k = 0; k < 6; k++)
      c[k] = rand_coord();
    // sometimes the point sits on the own or the group center, so the offset from that center is zero
    if ($urandom_range(0, 9) == 0)
      send_point(c[0], c[1], c[2], c[0], c[1], c[2], c[3], c[4], c[5], rand_weight());
    else if ($urandom_range(0, 9) == 0)
      send_point(c[0], c[1], c[2], c[3], c[4], c[5], c[0], c[1], c[2], rand_weight());
    else
      send_point(rand_coord(), rand_coord(), rand_coord(), c[0], c[1], c[2],
                 c[3], c[4], c[5], rand_weight());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  initial begin
    logic [31:0] ratios[N_PHASES]  = '{32'd65536, 32'd0, 32'd131071, 32'd32768,
                                       32'd65536, 32'd20000};
    logic [31:0] radii[N_PHASES]   = '{32'h7fffffff, 32'd0, 32'd65536,
                                       32'h00640000, 32'h7fffffff, 32'd12345678};
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    pos_x = '0; pos_y = '0; pos_z = '0;
    own_ctr_x = '0; own_ctr_y = '0; own_ctr_z = '0;
    grp_ctr_x = '0; grp_ctr_y = '0; grp_ctr_z = '0;
    weight     = '0;
    sink_mode  = 0;
    sender_quiet = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed points at reset config, then at full blend
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        write_reg(CFG_BLEND_RATIO, 32'd65536);
        write_reg(CFG_TARGET_RADIUS, 32'h00100000);
        write_reg(CFG_USE_OWN_CENTER, 32'd1);
      end
      // zero offset from either center
      send_point(32'h10000, 32'h20000, 32'h30000, 32'h10000, 32'h20000, 32'h30000,
                 32'h10000, 32'h20000, 32'h30000, ONE_Q16);
      send_point('0, '0, '0, '0, '0, '0, '0, '0, '0, 17'd0);
      // extreme coordinates and the largest offsets
      send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000, 32'h80000000, ONE_Q16);
      send_point(32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 17'h1ffff);
      // tiny offset, weight above one, weight zero
      send_point(32'd1, '0, '0, '0, '0, '0, '0, '0, '0, 17'h1ffff);
      send_point(32'hffffffff, 32'd1, 32'd1, '0, '0, '0, '0, '0, '0, 17'd0);
      send_point(32'h50000, 32'hfffb0000, 32'h0, 32'h10000, 32'h0, 32'h0,
                 32'hfff00000, 32'h1000, 32'h7, 17'd32768);
      drain();
    end

    // random phases through several register settings, extremes included
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_reg(CFG_BLEND_RATIO, ratios[ph]);
      write_reg(CFG_TARGET_RADIUS, radii[ph]);
      write_reg(CFG_USE_OWN_CENTER, 32'(ph % 2));
      if (ph == 1)
        sink_mode = 1;         // long hold-off while points keep coming
      if (ph == N_PHASES - 1) begin
        sink_mode = 2;
        sender_quiet = 1'b1;
      end
      for (int n = 0; n < PER_PHASE; n++)
        send_random();
      drain();
    end

    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
